/* hw/rtl/bpa_pkg.sv */
// Package: shared types and constants of the block pool allocator.
`default_nettype none

package bpa_pkg;

	// Default number of blocks in the pool
	localparam int unsigned POOL_SIZE_DEF = 32;

	// Fixed widths of the item fields
	localparam int unsigned IDX_IN_W  = 6;
	localparam int unsigned GRANT_W   = 5;
	localparam int unsigned SEQ_W     = 32;
	localparam int unsigned FREE_W    = 6;
	localparam int unsigned FAIL_W    = 32;
	localparam int unsigned STATUS_W  = 3;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FREED     = 3'd2,
		ST_FOREIGN   = 3'd3,
		ST_UNUSED    = 3'd4
	} status_t;

	typedef struct packed {
		op_t                 opcode;
		logic [IDX_IN_W-1:0] block_index;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [GRANT_W-1:0]  granted_index;
		logic [SEQ_W-1:0]    sequence_number;
		logic [FREE_W-1:0]   blocks_free;
		logic [FAIL_W-1:0]   failures;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/block_pool_free_stack_allocator.sv */
// Top level: block pool allocator with a LIFO free stack held in a synchronous memory.
// Results: a free or a failed allocate shows its result in the cycle after start is taken;
//   a granted allocate first reads the popped index from the synchronous stack memory
//   into rd_data_s1, then registers its result; busy is high for one cycle meanwhile.
// Throughput: one item per cycle for frees and failed allocates when busy is low; no item
//   is taken while busy. The receiver cannot stall; done marks each result for one cycle.
// Reset: arst_n clears the pool to full, all blocks unused and both counters to zero.
`default_nettype none

module block_pool_free_stack_allocator #(
	parameter int unsigned POOL_SIZE = bpa_pkg::POOL_SIZE_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire bpa_pkg::cmd_t    cmd,
	output logic                  done,
	output bpa_pkg::result_t      result
);
	import bpa_pkg::*;

	// Index width for stack entries and in-use bits; depth width holds POOL_SIZE itself
	localparam int unsigned IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int unsigned DW = $clog2(POOL_SIZE + 1);
	localparam logic [DW-1:0]       POOL_D = DW'(POOL_SIZE);
	localparam logic [IDX_IN_W-1:0] POOL_I = IDX_IN_W'(POOL_SIZE);

	// Free stack memory: one write and one registered read a cycle
	logic [IW-1:0]        stk_mem [POOL_SIZE];
	// Entry written since reset; an unwritten entry reads as its own address
	logic [POOL_SIZE-1:0] stk_vld_q;
	logic [POOL_SIZE-1:0] in_use_q;
	logic [DW-1:0]        depth_q;
	logic [FAIL_W-1:0]    fail_q;
	logic [SEQ_W-1:0]     seq_q;

	// Pop in flight: the read data arrives in the next cycle
	logic                 pend_s1;
	logic [IW-1:0]        rd_data_s1;
	logic [IW-1:0]        rd_addr_s1;
	logic                 rd_vld_s1;

	logic                 done_q;
	result_t              rsp_q;

	// Decode of the current command
	logic                 acc;
	logic                 is_alloc;
	logic                 idx_ok;
	logic [IW-1:0]        idx_i;
	logic                 used;
	logic                 empty;
	logic [DW-1:0]        depth_dec;
	logic [IW-1:0]        rd_addr;
	logic [IW-1:0]        wr_addr;
	logic                 rd_en;
	logic                 wr_en;
	logic                 free_ok;
	logic [IW-1:0]        blk;

	// Next state and result
	logic [DW-1:0]        depth_nx;
	logic [FAIL_W-1:0]    fail_nx;
	logic [SEQ_W-1:0]     seq_nx;
	logic                 load;
	result_t              rsp_d;
	logic [IW+GRANT_W-1:0] blk_ext;
	logic [DW+FREE_W-1:0]  depth_ext;

	always_comb begin
		acc       = start && !pend_s1;
		is_alloc  = (cmd.opcode == OP_ALLOC);
		idx_ok    = (cmd.block_index < POOL_I);
		idx_i     = cmd.block_index[IW-1:0];
		used      = idx_ok && in_use_q[idx_i];
		empty     = (depth_q == '0) || (depth_q > POOL_D);
		depth_dec = depth_q - DW'(1);
		rd_addr   = depth_dec[IW-1:0];
		wr_addr   = depth_q[IW-1:0];
		free_ok   = acc && !is_alloc && used;
		// Push only when the stack has room; a block in use is never on the stack
		wr_en     = free_ok && (depth_q < POOL_D);
		rd_en     = acc && is_alloc && !empty;
		blk       = rd_vld_s1 ? rd_data_s1 : rd_addr_s1;
	end

	// Next values of depth and counters
	always_comb begin
		depth_nx = depth_q;
		fail_nx  = fail_q;
		seq_nx   = seq_q;
		if (pend_s1) begin
			seq_nx = seq_q + SEQ_W'(1);
		end else if (rd_en) begin
			depth_nx = depth_dec;
		end else if (acc && is_alloc) begin
			fail_nx = fail_q + FAIL_W'(1);
		end else if (wr_en) begin
			depth_nx = depth_q + DW'(1);
		end
	end

	// Result assembly: granted allocates in the cycle after the pop, all else at once
	always_comb begin
		blk_ext   = {{GRANT_W{1'b0}}, blk};
		depth_ext = {{FREE_W{1'b0}}, depth_nx};
		load      = pend_s1 || (acc && !rd_en);
		rsp_d.status          = ST_ALLOCATED;
		rsp_d.granted_index   = '0;
		rsp_d.sequence_number = '0;
		rsp_d.blocks_free     = depth_ext[FREE_W-1:0];
		rsp_d.failures        = fail_nx;
		if (pend_s1) begin
			rsp_d.granted_index   = blk_ext[GRANT_W-1:0];
			rsp_d.sequence_number = seq_nx;
		end else if (is_alloc) begin
			rsp_d.status = ST_EMPTY;
		end else if (!idx_ok) begin
			rsp_d.status = ST_FOREIGN;
		end else if (!used) begin
			rsp_d.status = ST_UNUSED;
		end else begin
			rsp_d.status = ST_FREED;
		end
	end

	// Stack memory: push writes at the depth, pop reads one below it
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stk_mem[wr_addr] <= idx_i;
		end
		if (rd_en) begin
			rd_data_s1 <= stk_mem[rd_addr];
		end
	end

	// Hold the pop address and its written mark alongside the read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_addr_s1 <= rd_addr;
			rd_vld_s1  <= stk_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1   <= 1'b0;
			done_q    <= 1'b0;
			depth_q   <= POOL_D;
			fail_q    <= '0;
			seq_q     <= '0;
			in_use_q  <= '0;
			stk_vld_q <= '0;
		end else begin
			pend_s1 <= rd_en;
			done_q  <= load;
			depth_q <= depth_nx;
			fail_q  <= fail_nx;
			seq_q   <= seq_nx;
			if (wr_en) begin
				stk_vld_q[wr_addr] <= 1'b1;
			end
			// Mark the popped block in use, or release the freed one
			if (pend_s1) begin
				in_use_q[blk] <= 1'b1;
			end else if (free_ok) begin
				in_use_q[idx_i] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy   = pend_s1;
	assign done   = done_q;
	assign result = rsp_q;

endmodule

`default_nettype wire

/* hw/rtl/bpa_chk.sv */
// Checker: port-level properties of the block pool allocator, bound to the top level.
`default_nettype none

module bpa_chk #(
	parameter int unsigned POOL_SIZE = bpa_pkg::POOL_SIZE_DEF
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire bpa_pkg::cmd_t    cmd,
	input wire logic             done,
	input wire bpa_pkg::result_t result
);
	import bpa_pkg::*;

	localparam logic [FREE_W-1:0] POOL_F = FREE_W'(POOL_SIZE);

	// Every taken item answers in the next cycle or raises busy for the pop
	a_take_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("taken item neither answered nor pending");

	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("pending pop did not complete in one cycle");

	a_free_now: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.opcode == OP_FREE |=> done && !busy)
		else $error("free not answered in the next cycle");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.blocks_free <= POOL_F)
		else $error("free count above pool size");

	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_ALLOCATED |->
			result.granted_index == '0 && result.sequence_number == '0)
		else $error("grant fields set on a result without a grant");

endmodule

bind block_pool_free_stack_allocator bpa_chk #(.POOL_SIZE(POOL_SIZE)) u_bpa_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

`default_nettype wire
